// ===== sv/lfvs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lfvs_pkg;

   // Step counter and datapath sizes
   localparam int STEP_W     = 5;
   localparam int NUM_WORDS  = 7;
   localparam int WORD_SEL_W = $clog2(NUM_WORDS);
   localparam int TS_W       = 32;
   localparam int VARINT_BITS = 7;
   localparam int VOLT_W     = 16;
   localparam int PROD_W     = 23;

   // Frame constants
   localparam logic [7:0] FRAME_START = 8'h00;
   localparam logic [6:0] VOLT_SCALE  = 7'd100;

   // Word slots in the sample store
   localparam logic [WORD_SEL_W-1:0] W_GYRO_X  = 3'd0;
   localparam logic [WORD_SEL_W-1:0] W_GYRO_Y  = 3'd1;
   localparam logic [WORD_SEL_W-1:0] W_GYRO_Z  = 3'd2;
   localparam logic [WORD_SEL_W-1:0] W_ACCEL_X = 3'd3;
   localparam logic [WORD_SEL_W-1:0] W_ACCEL_Y = 3'd4;
   localparam logic [WORD_SEL_W-1:0] W_ACCEL_Z = 3'd5;
   localparam logic [WORD_SEL_W-1:0] W_VOLTS   = 3'd6;

   // Program addresses
   localparam logic [STEP_W-1:0] STEP_IDLE   = 5'd0;
   localparam logic [STEP_W-1:0] STEP_START  = 5'd1;
   localparam logic [STEP_W-1:0] STEP_VARINT = 5'd2;
   localparam logic [STEP_W-1:0] STEP_RSSI   = 5'd17;

   // Byte source select
   typedef enum logic [2:0] {
      SRC_ZERO,
      SRC_VARINT,
      SRC_WORD_HI,
      SRC_WORD_LO,
      SRC_RSSI
   } src_type;

   // Sequencer jump kinds
   typedef enum logic [1:0] {
      JMP_SEQ,
      JMP_WAIT_REQ,
      JMP_LOOP_MORE,
      JMP_GOTO
   } jump_type;

   typedef struct packed {
      logic                  emit;
      src_type               src;
      logic [WORD_SEL_W-1:0] word_sel;
      logic                  last;
      jump_type              jump;
      logic [STEP_W-1:0]     target;
   } ctrl_word_type;

   typedef struct packed {
      logic out_free;
      logic ts_more;
   } dp_status_type;

   function automatic ctrl_word_type cw(
      input logic                  emit,
      input src_type               src,
      input logic [WORD_SEL_W-1:0] word_sel,
      input logic                  last,
      input jump_type              jump,
      input logic [STEP_W-1:0]     target
   );
      ctrl_word_type w;
      w.emit     = emit;
      w.src      = src;
      w.word_sel = word_sel;
      w.last     = last;
      w.jump     = jump;
      w.target   = target;
      return w;
   endfunction

   // Microcode ROM
   function automatic ctrl_word_type ucode(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      unique case (step)
         STEP_IDLE:   w = cw(1'b0, SRC_ZERO,    W_GYRO_X,  1'b0, JMP_WAIT_REQ,  STEP_START);
         STEP_START:  w = cw(1'b1, SRC_ZERO,    W_GYRO_X,  1'b0, JMP_SEQ,       STEP_VARINT);
         STEP_VARINT: w = cw(1'b1, SRC_VARINT,  W_GYRO_X,  1'b0, JMP_LOOP_MORE, STEP_VARINT);
         5'd3:  w = cw(1'b1, SRC_WORD_HI, W_GYRO_X,  1'b0, JMP_SEQ,       STEP_IDLE);
         5'd4:  w = cw(1'b1, SRC_WORD_LO, W_GYRO_X,  1'b0, JMP_SEQ,       STEP_IDLE);
         5'd5:  w = cw(1'b1, SRC_WORD_HI, W_GYRO_Y,  1'b0, JMP_SEQ,       STEP_IDLE);
         5'd6:  w = cw(1'b1, SRC_WORD_LO, W_GYRO_Y,  1'b0, JMP_SEQ,       STEP_IDLE);
         5'd7:  w = cw(1'b1, SRC_WORD_HI, W_GYRO_Z,  1'b0, JMP_SEQ,       STEP_IDLE);
         5'd8:  w = cw(1'b1, SRC_WORD_LO, W_GYRO_Z,  1'b0, JMP_SEQ,       STEP_IDLE);
         5'd9:  w = cw(1'b1, SRC_WORD_HI, W_ACCEL_X, 1'b0, JMP_SEQ,       STEP_IDLE);
         5'd10: w = cw(1'b1, SRC_WORD_LO, W_ACCEL_X, 1'b0, JMP_SEQ,       STEP_IDLE);
         5'd11: w = cw(1'b1, SRC_WORD_HI, W_ACCEL_Y, 1'b0, JMP_SEQ,       STEP_IDLE);
         5'd12: w = cw(1'b1, SRC_WORD_LO, W_ACCEL_Y, 1'b0, JMP_SEQ,       STEP_IDLE);
         5'd13: w = cw(1'b1, SRC_WORD_HI, W_ACCEL_Z, 1'b0, JMP_SEQ,       STEP_IDLE);
         5'd14: w = cw(1'b1, SRC_WORD_LO, W_ACCEL_Z, 1'b0, JMP_SEQ,       STEP_IDLE);
         5'd15: w = cw(1'b1, SRC_WORD_HI, W_VOLTS,   1'b0, JMP_SEQ,       STEP_IDLE);
         5'd16: w = cw(1'b1, SRC_WORD_LO, W_VOLTS,   1'b0, JMP_SEQ,       STEP_IDLE);
         STEP_RSSI:   w = cw(1'b1, SRC_RSSI,    W_GYRO_X,  1'b1, JMP_GOTO,      STEP_IDLE);
         default: w = cw(1'b0, SRC_ZERO,  W_GYRO_X,  1'b0, JMP_GOTO,      STEP_IDLE);
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== sv/lfvs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sample channel
interface lfvs_req_if;
   logic               valid;
   logic               ready;
   logic [31:0]        timestamp;
   logic signed [15:0] gyro_x;
   logic signed [15:0] gyro_y;
   logic signed [15:0] gyro_z;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic [15:0]        battery_volts_q8;
   logic [7:0]         signal_strength;

   modport source (
      output valid, timestamp, gyro_x, gyro_y, gyro_z,
      output accel_x, accel_y, accel_z, battery_volts_q8, signal_strength,
      input  ready
   );
   modport sink (
      input  valid, timestamp, gyro_x, gyro_y, gyro_z,
      input  accel_x, accel_y, accel_z, battery_volts_q8, signal_strength,
      output ready
   );
endinterface

// Frame byte channel
interface lfvs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_last;

   modport source (output valid, frame_byte, frame_last, input ready);
   modport sink   (input valid, frame_byte, frame_last, output ready);
endinterface

`default_nettype wire

// ===== sv/log_frame_varint_serializer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Flight log main-frame serializer.
// req_chan takes one sample per item (valid/ready). rsp_chan returns the
// frame one byte per item: a zero start byte, the timestamp as a 1 to 5 byte
// LEB128 varint, six 16-bit sensor words and the centivolt word high byte
// first, then the RSSI byte with frame_last set. A frame is 17 to 21 bytes.
// A sample is taken only while the sequencer sits at its wait step, so
// req_chan.ready is high between frames and low for the whole frame.
// After a sample is taken the step counter leaves its wait step and the start
// byte is registered, then one byte per cycle while rsp_chan.ready stays high,
// set by the microcode step counter: one byte per step, the varint step repeating per byte.
// The output byte sits in a register; when the receiver holds rsp_chan.ready
// low the step counter stops and the byte holds until taken.
// Reset (synchronous, active high) returns the sequencer to the wait step and
// drops rsp_chan.valid; a frame in flight is discarded.
module log_frame_varint_serializer (
   input  wire logic   clock,
   input  wire logic   reset,
   lfvs_req_if.sink    req_chan,
   lfvs_rsp_if.source  rsp_chan
);

   lfvs_pkg::ctrl_word_type ctrl;
   lfvs_pkg::dp_status_type status;
   logic                    load;
   logic                    req_ready;

   lfvs_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .status    (status),
      .ctrl      (ctrl),
      .req_ready (req_ready),
      .load      (load)
   );

   lfvs_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .load             (load),
      .ctrl             (ctrl),
      .timestamp        (req_chan.timestamp),
      .gyro_x           (req_chan.gyro_x),
      .gyro_y           (req_chan.gyro_y),
      .gyro_z           (req_chan.gyro_z),
      .accel_x          (req_chan.accel_x),
      .accel_y          (req_chan.accel_y),
      .accel_z          (req_chan.accel_z),
      .battery_volts_q8 (req_chan.battery_volts_q8),
      .signal_strength  (req_chan.signal_strength),
      .rsp_ready        (rsp_chan.ready),
      .status           (status),
      .rsp_valid        (rsp_chan.valid),
      .frame_byte       (rsp_chan.frame_byte),
      .frame_last       (rsp_chan.frame_last)
   );

   assign req_chan.ready = req_ready;

   // A taken sample starts a frame: no second sample the next cycle
   a_busy_after_load: assert property (@(posedge clock) disable iff (reset)
      load |=> !req_ready)
      else $error("sample accepted twice in a row");

   // Issuing the last byte returns the sequencer to the wait step
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (ctrl.emit && ctrl.last && status.out_free) |=> req_ready)
      else $error("sequencer did not return to wait after last byte");

   // Waiting for a sample never issues a byte
   a_no_emit_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !ctrl.emit)
      else $error("byte issued while waiting for a sample");

endmodule

`default_nettype wire

// ===== sv/lfvs_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lfvs_sequencer (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire lfvs_pkg::dp_status_type status,
   output lfvs_pkg::ctrl_word_type     ctrl,
   output logic                        req_ready,
   output logic                        load
);

   logic [lfvs_pkg::STEP_W-1:0] step_ff;
   logic [lfvs_pkg::STEP_W-1:0] step_in;
   logic                        fire;

   // Control word fetch
   assign ctrl      = lfvs_pkg::ucode(step_ff);
   assign fire      = ctrl.emit & status.out_free;
   assign req_ready = (ctrl.jump == lfvs_pkg::JMP_WAIT_REQ);
   assign load      = req_ready & req_valid;

   // Next step
   always_comb begin
      step_in = step_ff;
      unique case (ctrl.jump)
         lfvs_pkg::JMP_WAIT_REQ: begin
            if (req_valid) step_in = ctrl.target;
         end
         lfvs_pkg::JMP_SEQ: begin
            if (fire) step_in = step_ff + 1'b1;
         end
         lfvs_pkg::JMP_LOOP_MORE: begin
            // stay on the varint step while high bits remain
            if (fire && !status.ts_more) step_in = step_ff + 1'b1;
         end
         lfvs_pkg::JMP_GOTO: begin
            if (fire || !ctrl.emit) step_in = ctrl.target;
         end
         default: step_in = lfvs_pkg::STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= lfvs_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/lfvs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lfvs_datapath (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  wire lfvs_pkg::ctrl_word_type ctrl,
   input  wire logic [31:0]             timestamp,
   input  wire logic [15:0]             gyro_x,
   input  wire logic [15:0]             gyro_y,
   input  wire logic [15:0]             gyro_z,
   input  wire logic [15:0]             accel_x,
   input  wire logic [15:0]             accel_y,
   input  wire logic [15:0]             accel_z,
   input  wire logic [15:0]             battery_volts_q8,
   input  wire logic [7:0]              signal_strength,
   input  wire logic                    rsp_ready,
   output lfvs_pkg::dp_status_type      status,
   output logic                         rsp_valid,
   output logic [7:0]                   frame_byte,
   output logic                         frame_last
);

   logic [15:0]                 word_ff [lfvs_pkg::NUM_WORDS];
   logic [lfvs_pkg::TS_W-1:0]   ts_ff;
   logic [7:0]                  rssi_ff;
   logic [lfvs_pkg::PROD_W-1:0] volt_prod;
   logic [lfvs_pkg::VOLT_W-1:0] centivolts;
   logic                        rsp_valid_ff;
   logic [7:0]                  byte_ff;
   logic                        last_ff;
   logic [7:0]                  byte_in;
   logic [15:0]                 word_sel;
   logic                        ts_more;
   logic                        out_free;
   logic                        fire;

   // q * 100 / 256, truncated
   assign volt_prod  = lfvs_pkg::PROD_W'(battery_volts_q8) *
                       lfvs_pkg::PROD_W'(lfvs_pkg::VOLT_SCALE);
   assign centivolts = lfvs_pkg::VOLT_W'(volt_prod[lfvs_pkg::PROD_W-1:8]);

   assign ts_more  = |ts_ff[lfvs_pkg::TS_W-1:lfvs_pkg::VARINT_BITS];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign fire     = ctrl.emit & out_free;
   assign status   = '{out_free: out_free, ts_more: ts_more};
   assign word_sel = word_ff[ctrl.word_sel];

   // Sample store and varint shifter
   always_ff @(posedge clock) begin
      if (load) begin
         word_ff[lfvs_pkg::W_GYRO_X]  <= gyro_x;
         word_ff[lfvs_pkg::W_GYRO_Y]  <= gyro_y;
         word_ff[lfvs_pkg::W_GYRO_Z]  <= gyro_z;
         word_ff[lfvs_pkg::W_ACCEL_X] <= accel_x;
         word_ff[lfvs_pkg::W_ACCEL_Y] <= accel_y;
         word_ff[lfvs_pkg::W_ACCEL_Z] <= accel_z;
         word_ff[lfvs_pkg::W_VOLTS]   <= centivolts;
         rssi_ff                      <= signal_strength;
         ts_ff                        <= timestamp;
      end else if (fire && ctrl.src == lfvs_pkg::SRC_VARINT) begin
         ts_ff <= ts_ff >> lfvs_pkg::VARINT_BITS;
      end
   end

   // Byte select
   always_comb begin
      case (ctrl.src)
         lfvs_pkg::SRC_ZERO:    byte_in = lfvs_pkg::FRAME_START;
         lfvs_pkg::SRC_VARINT:  byte_in = {ts_more, ts_ff[lfvs_pkg::VARINT_BITS-1:0]};
         lfvs_pkg::SRC_WORD_HI: byte_in = word_sel[15:8];
         lfvs_pkg::SRC_WORD_LO: byte_in = word_sel[7:0];
         lfvs_pkg::SRC_RSSI:    byte_in = rssi_ff;
         default:               byte_in = lfvs_pkg::FRAME_START;
      endcase
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         byte_ff <= byte_in;
         last_ff <= ctrl.last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign frame_byte = byte_ff;
   assign frame_last = last_ff;

endmodule

`default_nettype wire
